@@ rtl/hkr_pkg.sv @@
package hkr_pkg;

    // Sizes of the descriptor and the train store.
    localparam int DESC_WORDS = 4;
    localparam int TRAIN_MAX  = 1024;
    localparam int WORD_W     = 64;

    // The Hamming unit consumes one digit of the XOR word per cycle.
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = WORD_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(DIGITS + 1);
    localparam int PC_W    = $clog2(DIGIT_W + 1);

    localparam int DIST_W  = $clog2(DESC_WORDS * WORD_W + 1);
    localparam int DISTV_W = (DIST_W > 10) ? DIST_W : 10;

    localparam int ROW_W     = $clog2(TRAIN_MAX);
    localparam int ROWS_W    = $clog2(TRAIN_MAX + 1);
    localparam int MEM_DEPTH = TRAIN_MAX * DESC_WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int WPOS_W    = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;

    localparam int THR_W      = 9;
    localparam int PROD_W     = DISTV_W + THR_W;
    localparam int CMD_W      = 2;
    localparam int QIDX_W     = 16;
    localparam int OUT_DIST_W = 10;
    localparam int OUT_ROW_W  = 10;

    localparam logic [WPOS_W-1:0]  WPOS_LAST = WPOS_W'(DESC_WORDS - 1);
    localparam logic [DISTV_W-1:0] NO_DIST   = DISTV_W'(1000);
    localparam logic [THR_W-1:0]   THR_RESET = THR_W'(179);
    localparam logic [ROWS_W-1:0]  ROWS_FULL = ROWS_W'(TRAIN_MAX);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SHIFT,
        ST_RANK,
        ST_MUL,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
    } pop_ctrl_t;

    typedef struct packed {
        logic              busy;
        logic [DIST_W-1:0] ones_total;
    } pop_stat_t;

endpackage

@@ rtl/hkr_popser.sv @@
module hkr_popser
    import hkr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pop_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] word_in,
    output pop_stat_t         stat
);

    logic [DCNT_W-1:0] cnt_reg;
    logic [DCNT_W-1:0] cnt_next;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] acc_next;
    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;

    function automatic logic [PC_W-1:0] digit_ones(input logic [DIGIT_W-1:0] d);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            n = n + PC_W'(d[i]);
        end
        return n;
    endfunction

    // A load replaces the word; the accumulator keeps running across the
    // words of one row unless the load also clears it.
    always_comb
    begin
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        if (ctrl.load)
        begin
            shift_next = word_in;
            cnt_next   = DCNT_W'(DIGITS);
            if (ctrl.clear)
            begin
                acc_next = '0;
            end
        end
        else if (cnt_reg != '0)
        begin
            shift_next = shift_reg >> DIGIT_W;
            cnt_next   = cnt_reg - DCNT_W'(1);
            acc_next   = acc_reg + DIST_W'(digit_ones(shift_reg[DIGIT_W-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign stat.busy       = (cnt_reg != '0);
    assign stat.ones_total = acc_reg;

endmodule

@@ rtl/hamming_knn2_ratio_matcher_unit.sv @@
// Each query scans all stored train rows; with none stored it skips the scan and reports.
// Each 64-bit word takes one store read, one load, eight one-byte popcount steps and a
// check that the unit has finished; each row then takes a rank step. busy stays high
// through the result strobe cycle; train, clear and other query items are taken only
// while busy is low. Reset clears the train set, word positions, query counter and sets
// the ratio limit to 179; done cannot be stalled.
module hamming_knn2_ratio_matcher_unit
    import hkr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [WORD_W-1:0]     desc_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_W-1:0]      cfg_data,
    output logic                  done,
    output logic [QIDX_W-1:0]     query_index,
    output logic                  best_valid,
    output logic [OUT_ROW_W-1:0]  best_index,
    output logic [OUT_DIST_W-1:0] best_distance,
    output logic [OUT_DIST_W-1:0] second_distance,
    output logic                  accepted
);

    state_t state_reg;
    state_t state_next;

    logic [THR_W-1:0]   thr_reg;
    logic [THR_W-1:0]   thr_next;
    logic [ROWS_W-1:0]  train_rows_reg;
    logic [ROWS_W-1:0]  train_rows_next;
    logic [WPOS_W-1:0]  train_pos_reg;
    logic [WPOS_W-1:0]  train_pos_next;
    logic [WPOS_W-1:0]  query_pos_reg;
    logic [WPOS_W-1:0]  query_pos_next;
    logic [QIDX_W-1:0]  query_counter_reg;
    logic [QIDX_W-1:0]  query_counter_next;

    logic [ROW_W-1:0]   scan_row_reg;
    logic [ROW_W-1:0]   scan_row_next;
    logic [WPOS_W-1:0]  scan_wpos_reg;
    logic [WPOS_W-1:0]  scan_wpos_next;
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [ADDR_W-1:0]  scan_addr_next;
    logic               have_best_reg;
    logic               have_best_next;
    logic               have_second_reg;
    logic               have_second_next;

    logic [DISTV_W-1:0] best_reg;
    logic [DISTV_W-1:0] best_next;
    logic [DISTV_W-1:0] second_reg;
    logic [DISTV_W-1:0] second_next;
    logic [ROW_W-1:0]   best_row_reg;
    logic [ROW_W-1:0]   best_row_next;
    logic [DISTV_W-1:0] bd_reg;
    logic [DISTV_W-1:0] bd_next;
    logic [DISTV_W-1:0] sd_reg;
    logic [DISTV_W-1:0] sd_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;

    logic [WORD_W-1:0]  store_mem [MEM_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [WORD_W-1:0]  query_words_reg [DESC_WORDS];

    logic               in_acc;
    logic               launch;
    logic               last_row;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DISTV_W-1:0] row_dist;
    logic               ratio_pass;
    pop_ctrl_t          pop_ctrl;
    pop_stat_t          pop_stat;

    assign in_acc   = start && !busy;
    assign launch   = in_acc && (cmd == CMD_QUERY) && (query_pos_reg == WPOS_LAST);
    assign last_row = ((ROWS_W'(scan_row_reg) + ROWS_W'(1)) == train_rows_reg);
    assign wr_addr  = ADDR_W'(train_rows_reg[ROW_W-1:0]) * ADDR_W'(DESC_WORDS)
                      + ADDR_W'(train_pos_reg);
    assign row_dist = DISTV_W'(pop_stat.ones_total);

    hkr_popser u_popser (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (pop_ctrl),
        .word_in (rd_data_reg ^ query_words_reg[scan_wpos_reg]),
        .stat    (pop_stat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = (train_rows_reg == '0) ? ST_MUL : ST_READ;
                end
            end
            ST_READ:   state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_SHIFT;
            ST_SHIFT:
            begin
                if (!pop_stat.busy)
                begin
                    state_next = (scan_wpos_reg == WPOS_LAST) ? ST_RANK : ST_READ;
                end
            end
            ST_RANK:   state_next = last_row ? ST_MUL : ST_READ;
            ST_MUL:    state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the control.
    always_comb
    begin
        busy           = (state_reg != ST_IDLE);
        done           = (state_reg == ST_REPORT);
        cfg_ready      = 1'b1;
        pop_ctrl.load  = (state_reg == ST_LOAD);
        pop_ctrl.clear = (state_reg == ST_LOAD) && (scan_wpos_reg == '0);
        mem_we         = in_acc && (cmd == CMD_TRAIN) && (train_rows_reg != ROWS_FULL);
    end

    // Datapath next values.
    always_comb
    begin
        thr_next           = thr_reg;
        train_rows_next    = train_rows_reg;
        train_pos_next     = train_pos_reg;
        query_pos_next     = query_pos_reg;
        query_counter_next = query_counter_reg;
        scan_row_next      = scan_row_reg;
        scan_wpos_next     = scan_wpos_reg;
        scan_addr_next     = scan_addr_reg;
        have_best_next     = have_best_reg;
        have_second_next   = have_second_reg;
        best_next          = best_reg;
        second_next        = second_reg;
        best_row_next      = best_row_reg;
        bd_next            = bd_reg;
        sd_next            = sd_reg;
        prod_next          = prod_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        if (in_acc)
        begin
            case (cmd)
                CMD_TRAIN:
                begin
                    if (train_rows_reg != ROWS_FULL)
                    begin
                        if (train_pos_reg == WPOS_LAST)
                        begin
                            train_pos_next  = '0;
                            train_rows_next = train_rows_reg + ROWS_W'(1);
                        end
                        else
                        begin
                            train_pos_next = train_pos_reg + WPOS_W'(1);
                        end
                    end
                end
                CMD_QUERY:
                begin
                    if (query_pos_reg == WPOS_LAST)
                    begin
                        query_pos_next = '0;
                    end
                    else
                    begin
                        query_pos_next = query_pos_reg + WPOS_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    train_rows_next = '0;
                    train_pos_next  = '0;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    scan_row_next    = '0;
                    scan_wpos_next   = '0;
                    scan_addr_next   = '0;
                    have_best_next   = 1'b0;
                    have_second_next = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                if (!pop_stat.busy && (scan_wpos_reg != WPOS_LAST))
                begin
                    scan_wpos_next = scan_wpos_reg + WPOS_W'(1);
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
            end
            ST_RANK:
            begin
                // Strict less-than keeps the earliest row on a tie.
                if (!have_best_reg || (row_dist < best_reg))
                begin
                    if (have_best_reg)
                    begin
                        second_next      = best_reg;
                        have_second_next = 1'b1;
                    end
                    best_next      = row_dist;
                    best_row_next  = scan_row_reg;
                    have_best_next = 1'b1;
                end
                else if (!have_second_reg || (row_dist < second_reg))
                begin
                    second_next      = row_dist;
                    have_second_next = 1'b1;
                end
                scan_wpos_next = '0;
                scan_addr_next = scan_addr_reg + ADDR_W'(1);
                scan_row_next  = scan_row_reg + ROW_W'(1);
            end
            ST_MUL:
            begin
                bd_next   = have_best_reg ? best_reg : NO_DIST;
                sd_next   = have_second_reg ? second_reg : NO_DIST;
                prod_next = PROD_W'(thr_reg)
                            * PROD_W'(have_second_reg ? second_reg : NO_DIST);
            end
            ST_REPORT:
            begin
                query_counter_next = query_counter_reg + QIDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            thr_reg           <= THR_RESET;
            train_rows_reg    <= '0;
            train_pos_reg     <= '0;
            query_pos_reg     <= '0;
            query_counter_reg <= '0;
            scan_row_reg      <= '0;
            scan_wpos_reg     <= '0;
            scan_addr_reg     <= '0;
            have_best_reg     <= 1'b0;
            have_second_reg   <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            thr_reg           <= thr_next;
            train_rows_reg    <= train_rows_next;
            train_pos_reg     <= train_pos_next;
            query_pos_reg     <= query_pos_next;
            query_counter_reg <= query_counter_next;
            scan_row_reg      <= scan_row_next;
            scan_wpos_reg     <= scan_wpos_next;
            scan_addr_reg     <= scan_addr_next;
            have_best_reg     <= have_best_next;
            have_second_reg   <= have_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        second_reg   <= second_next;
        best_row_reg <= best_row_next;
        bd_reg       <= bd_next;
        sd_reg       <= sd_next;
        prod_reg     <= prod_next;
        if (in_acc && (cmd == CMD_QUERY))
        begin
            query_words_reg[query_pos_reg] <= desc_word;
        end
    end

    // Train store: one write port for incoming train words, one registered read
    // port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wr_addr] <= desc_word;
        end
        rd_data_reg <= store_mem[scan_addr_reg];
    end

    assign ratio_pass      = (PROD_W'({bd_reg, 8'd0}) < prod_reg);
    assign query_index     = query_counter_reg;
    assign best_valid      = have_best_reg;
    assign best_index      = have_best_reg ? OUT_ROW_W'(best_row_reg) : '0;
    assign best_distance   = OUT_DIST_W'(bd_reg);
    assign second_distance = OUT_DIST_W'(sd_reg);
    assign accepted        = have_best_reg && ratio_pass;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !mem_we)
        else $error("train store written during a scan");

    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        train_rows_reg <= ROWS_FULL)
        else $error("train row count beyond the store size");

    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bd_reg <= sd_reg))
        else $error("best distance above second distance");

    a_load_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ctrl.load |-> !pop_stat.busy)
        else $error("Hamming unit loaded while still shifting");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import hkr_pkg::*;
();

    localparam int CLK_PERIOD = 8;
    localparam longint TIMEOUT_CYCLES = 10_000_000;
    localparam int ITEMS_TARGET = 580;
    localparam int ROW_CAP = 40;
    localparam int SETTLE_CYCLES = 100;

    // The fourth command code has no function in the block.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] ONES = '1;
    localparam logic [WORD_W-1:0] PATTERN = 64'h0123_4567_89AB_CDEF;

    typedef logic [DESC_WORDS*WORD_W-1:0] desc_t;

    typedef struct packed {
        logic [QIDX_W-1:0]     qidx;
        logic                  hit;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_DIST_W-1:0] d1;
        logic [OUT_DIST_W-1:0] d2;
        logic                  ok;
    } match_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [WORD_W-1:0] word;
        logic              typed;
        match_t            want;
    } step_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      cmd;
    logic [WORD_W-1:0]     desc_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [THR_W-1:0]      cfg_data;
    logic                  done;
    logic [QIDX_W-1:0]     query_index;
    logic                  best_valid;
    logic [OUT_ROW_W-1:0]  best_index;
    logic [OUT_DIST_W-1:0] best_distance;
    logic [OUT_DIST_W-1:0] second_distance;
    logic                  accepted;

    // Shadow of the matcher state.
    logic [WORD_W-1:0] train_mem [MEM_DEPTH];
    logic [WORD_W-1:0] query_buf [DESC_WORDS];
    int unsigned       rows_stored;
    int unsigned       train_pos;
    int unsigned       query_pos;
    logic [QIDX_W-1:0] query_count;
    logic [THR_W-1:0]  ratio_limit;

    match_t    expected_matches[$];
    step_row_t step_table[$];
    logic [THR_W-1:0] limit_plan [4] = '{9'd0, 9'd256, 9'd1, THR_RESET};

    int errors;
    int items_sent;
    int burst_left;

    hamming_knn2_ratio_matcher_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .desc_word      (desc_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .query_index    (query_index),
        .best_valid     (best_valid),
        .best_index     (best_index),
        .best_distance  (best_distance),
        .second_distance(second_distance),
        .accepted       (accepted)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic match_t typed_match(input int unsigned qidx, input int unsigned hit,
                                           input int unsigned row, input int unsigned d1,
                                           input int unsigned d2, input int unsigned ok);
        match_t m;
        m.qidx = QIDX_W'(qidx);
        m.hit  = hit[0];
        m.row  = OUT_ROW_W'(row);
        m.d1   = OUT_DIST_W'(d1);
        m.d2   = OUT_DIST_W'(d2);
        m.ok   = ok[0];
        return m;
    endfunction

    // Scan every stored row against the query buffer, keeping the two nearest.
    function automatic match_t rank_query();
        int unsigned d;
        int unsigned best;
        int unsigned second;
        int unsigned best_row;
        int unsigned r;
        int unsigned k;
        bit          have_best;
        bit          have_second;
        match_t      m;
        have_best = 1'b0;
        have_second = 1'b0;
        best = 0;
        second = 0;
        best_row = 0;
        for (r = 0; r < rows_stored; r++)
        begin
            d = 0;
            for (k = 0; k < DESC_WORDS; k++)
                d += $countones(query_buf[k] ^ train_mem[r * DESC_WORDS + k]);
            if (!have_best || d < best)
            begin
                if (have_best)
                begin
                    second = best;
                    have_second = 1'b1;
                end
                best = d;
                best_row = r;
                have_best = 1'b1;
            end
            else if (!have_second || d < second)
            begin
                second = d;
                have_second = 1'b1;
            end
        end
        if (!have_best)
            best = NO_DIST;
        if (!have_second)
            second = NO_DIST;
        m.qidx = query_count;
        m.hit  = have_best;
        m.row  = have_best ? OUT_ROW_W'(best_row) : '0;
        m.d1   = OUT_DIST_W'(best);
        m.d2   = OUT_DIST_W'(second);
        m.ok   = have_best && (best * 256 < ratio_limit * second);
        return m;
    endfunction

    // Apply one item to the shadow state; returns 1 when it finishes a query.
    function automatic bit advance_model(input logic [CMD_W-1:0] op,
                                         input logic [WORD_W-1:0] word, output match_t m);
        bit fired;
        fired = 1'b0;
        m = '0;
        case (op)
            CMD_TRAIN:
            begin
                if (rows_stored < TRAIN_MAX)
                begin
                    train_mem[rows_stored * DESC_WORDS + train_pos] = word;
                    train_pos++;
                    if (train_pos == DESC_WORDS)
                    begin
                        train_pos = 0;
                        rows_stored++;
                    end
                end
            end
            CMD_QUERY:
            begin
                query_buf[query_pos] = word;
                query_pos++;
                if (query_pos == DESC_WORDS)
                begin
                    query_pos = 0;
                    m = rank_query();
                    query_count++;
                    fired = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                rows_stored = 0;
                train_pos = 0;
            end
            default:
            begin
            end
        endcase
        return fired;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic desc_t random_desc();
        desc_t v;
        int    k;
        for (k = 0; k < DESC_WORDS; k++)
            v[k*WORD_W +: WORD_W] = rand_word();
        return v;
    endfunction

    function automatic desc_t stored_row(input int unsigned r);
        desc_t v;
        int    k;
        for (k = 0; k < DESC_WORDS; k++)
            v[k*WORD_W +: WORD_W] = train_mem[r * DESC_WORDS + k];
        return v;
    endfunction

    function automatic desc_t flip_bits(input desc_t v, input int n);
        int i;
        for (i = 0; i < n; i++)
            v[$urandom_range(0, DESC_WORDS * WORD_W - 1)] ^= 1'b1;
        return v;
    endfunction

    task automatic add_step(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word,
                            input logic typed, input match_t want);
        step_row_t s;
        s.op = op;
        s.word = word;
        s.typed = typed;
        s.want = want;
        step_table = {step_table, s};
    endtask

    // Offer one item; the sender pauses between bursts of random length.
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word,
                             input logic typed, input match_t want);
        match_t m;
        bit     took;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        cmd <= op;
        desc_word <= word;
        do
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        while (!took);
        if (advance_model(op, word, m))
            expected_matches = {expected_matches, (typed ? want : m)};
        if (op != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_desc(input logic [CMD_W-1:0] op, input desc_t v);
        int k;
        for (k = 0; k < DESC_WORDS; k++)
            send_item(op, v[k*WORD_W +: WORD_W], 1'b0, '0);
    endtask

    task automatic drain(input int settle);
        start <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_ratio_limit(input logic [THR_W-1:0] value);
        bit took;
        drain(8);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid <= 1'b0;
        ratio_limit = value;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Results are strobed for one cycle; sample them mid-cycle.
    always @(negedge clk)
    begin
        match_t want;
        if (rst_n && done)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("result for query_index %0d with no query pending", query_index);
                errors++;
            end
            else
            begin
                want = expected_matches.pop_front();
                check_field("query_index", want.qidx, query_index);
                check_field("best_valid", want.hit, best_valid);
                check_field("best_index", want.row, best_index);
                check_field("best_distance", want.d1, best_distance);
                check_field("second_distance", want.d2, second_distance);
                check_field("accepted", want.ok, accepted);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int          i;
        int          pick;
        int          plan_idx;
        int          next_cfg;
        desc_t       d;
        logic [THR_W-1:0] limit;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_TRAIN;
        desc_word = '0;
        cfg_valid = 1'b0;
        cfg_data = THR_RESET;
        rows_stored = 0;
        train_pos = 0;
        query_pos = 0;
        query_count = '0;
        ratio_limit = THR_RESET;
        errors = 0;
        items_sent = 0;
        burst_left = 0;

        // A query with an empty train set; the unused command in between is dropped.
        add_step(CMD_QUERY, ONES, 1'b0, '0);
        add_step(CMD_UNUSED, ONES, 1'b0, '0);
        add_step(CMD_QUERY, '0, 1'b0, '0);
        add_step(CMD_QUERY, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0);
        add_step(CMD_QUERY, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1,
                 typed_match(0, 0, 0, NO_DIST, NO_DIST, 0));
        // Two identical zero rows: the earlier row wins the tie, and with both
        // distances zero the ratio test cannot pass.
        for (i = 0; i < 2 * DESC_WORDS; i++)
            add_step(CMD_TRAIN, '0, 1'b0, '0);
        for (i = 0; i < DESC_WORDS - 1; i++)
            add_step(CMD_QUERY, '0, 1'b0, '0);
        add_step(CMD_QUERY, '0, 1'b1, typed_match(1, 1, 0, 0, 0, 0));
        // Half a query is kept across a clear, half a train row is dropped.
        add_step(CMD_QUERY, PATTERN, 1'b0, '0);
        add_step(CMD_QUERY, ~PATTERN, 1'b0, '0);
        add_step(CMD_TRAIN, ONES, 1'b0, '0);
        add_step(CMD_TRAIN, ONES, 1'b0, '0);
        add_step(CMD_CLEAR, ONES, 1'b0, '0);
        for (i = 0; i < DESC_WORDS; i++)
            add_step(CMD_TRAIN, ONES, 1'b0, '0);
        add_step(CMD_QUERY, '0, 1'b0, '0);
        add_step(CMD_QUERY, ONES, 1'b1, typed_match(2, 1, 0, 128, NO_DIST, 1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (step_table[i])
            send_item(step_table[i].op, step_table[i].word, step_table[i].typed,
                      step_table[i].want);

        send_item(CMD_CLEAR, rand_word(), 1'b0, '0);

        items_sent = 0;
        plan_idx = 0;
        next_cfg = 0;
        while (items_sent < ITEMS_TARGET)
        begin
            if (items_sent >= next_cfg)
            begin
                limit = (plan_idx < 4) ? limit_plan[plan_idx] : THR_W'($urandom_range(0, 256));
                set_ratio_limit(limit);
                plan_idx++;
                next_cfg = items_sent + $urandom_range(90, 140);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8 || rows_stored >= ROW_CAP)
                send_item(CMD_CLEAR, rand_word(), 1'b0, '0);
            else if (pick < 45)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 7))
                        0: d = '0;
                        1: d = '1;
                        2, 3: d = (rows_stored != 0)
                                  ? flip_bits(stored_row($urandom_range(0, rows_stored - 1)),
                                              $urandom_range(0, 3))
                                  : random_desc();
                        default: d = random_desc();
                    endcase
                    send_desc(CMD_TRAIN, d);
                end
            end
            else if (pick < 88)
            begin
                // Mostly near a stored row, so that the ratio test has work to do.
                if (rows_stored != 0 && $urandom_range(0, 4) != 0)
                    d = flip_bits(stored_row($urandom_range(0, rows_stored - 1)),
                                  ($urandom_range(0, 2) == 0) ? $urandom_range(0, 60)
                                                              : $urandom_range(0, 6));
                else
                    d = ($urandom_range(0, 5) == 0) ? '1 : random_desc();
                send_desc(CMD_QUERY, d);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_item(CMD_UNUSED, rand_word(), 1'b0, '0);
                    1:
                    begin
                        repeat ($urandom_range(1, DESC_WORDS - 1))
                            send_item(CMD_TRAIN, rand_word(), 1'b0, '0);
                        send_item(CMD_CLEAR, rand_word(), 1'b0, '0);
                    end
                    default:
                    begin
                        repeat ($urandom_range(1, DESC_WORDS - 1))
                            send_item(CMD_QUERY, rand_word(), 1'b0, '0);
                    end
                endcase
            end
        end

        drain(SETTLE_CYCLES);
        if (errors == 0 && expected_matches.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ hamming_knn2_ratio_matcher_unit.f @@
rtl/hkr_pkg.sv
rtl/hkr_popser.sv
rtl/hamming_knn2_ratio_matcher_unit.sv
tb/tb_top.sv
